// ----- design/rsbi_pkg.sv -----
// Shared types and constants for the ray segment / box intersection unit.
package rsbi_pkg;

    localparam int unsigned Q_BITS     = 16;
    localparam int unsigned T_W        = Q_BITS + 1;
    localparam int unsigned DIV_STAGES = T_W;
    localparam int unsigned ADDR_W     = 5;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_MAX_X = 3'd3;
    localparam logic [2:0] REG_MAX_Y = 3'd4;
    localparam logic [2:0] REG_MAX_Z = 3'd5;

    localparam logic signed [31:0] BOX_MIN_RST = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] BOX_MAX_RST = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic signed [31:0] delta_z;
    } t_ray;

    typedef struct packed {
        logic               hit;
        logic               origin_inside;
        logic [T_W-1:0]     t_param;
        logic [1:0]         normal_axis;
        logic               normal_negative;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
    } t_result;

    // per-axis working set carried down the divider
    typedef struct packed {
        logic signed [31:0] o;
        logic signed [31:0] d;
        logic               ins;
        logic               neg;
        logic               rej;
        logic [32:0]        rem;
        logic [31:0]        dv;
        logic [T_W-1:0]     q;
    } t_axis_st;

    function automatic logic [32:0] mag34(input logic signed [33:0] v);
        logic [33:0] m;
        m = v[33] ? 34'(-v) : 34'(v);
        return m[32:0];
    endfunction

endpackage

// ----- design/rsbi_if.sv -----
// Valid/ready channel interfaces for rays in and results out.
interface rsbi_in_if import rsbi_pkg::*; ();
    logic valid;
    logic ready;
    t_ray data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rsbi_out_if import rsbi_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/ray_segment_box_intersect_unit.sv -----
// Top level: pipelined ray segment against axis-aligned box test.
// One ray beat is taken every cycle while the pipe advances and passes through
// one classify stage, 17 restoring-division stages (one quotient bit each,
// three axes side by side), a face-select stage, a multiply stage and the
// bounds-check/output register. The whole pipe advances when the output
// register is empty or being taken, so a stall holds every stage. The box
// sits in six APB registers at 4*i (min x,y,z then max x,y,z) and must only
// be written while no ray is in flight.
module ray_segment_box_intersect_unit import rsbi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    rsbi_in_if.sink           i_ray,
    rsbi_out_if.source        o_res
);

    logic signed [31:0] r_box_min [3];
    logic signed [31:0] r_box_max [3];

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_box_min[a] <= BOX_MIN_RST;
                r_box_max[a] <= BOX_MAX_RST;
            end
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_MIN_X: r_box_min[0] <= pwdata;
                REG_MIN_Y: r_box_min[1] <= pwdata;
                REG_MIN_Z: r_box_min[2] <= pwdata;
                REG_MAX_X: r_box_max[0] <= pwdata;
                REG_MAX_Y: r_box_max[1] <= pwdata;
                REG_MAX_Z: r_box_max[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_MIN_X: prdata = r_box_min[0];
            REG_MIN_Y: prdata = r_box_min[1];
            REG_MIN_Z: prdata = r_box_min[2];
            REG_MAX_X: prdata = r_box_max[0];
            REG_MAX_Y: prdata = r_box_max[1];
            REG_MAX_Z: prdata = r_box_max[2];
            default:   prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic r_out_v;
    logic adv;
    assign adv         = !r_out_v || o_res.ready;
    assign i_ray.ready = adv;

    // ---------------- classify ----------------
    logic signed [31:0] in_o [3];
    logic signed [31:0] in_d [3];
    t_axis_st           n_ax0 [3];

    assign in_o[0] = i_ray.data.origin_x;
    assign in_o[1] = i_ray.data.origin_y;
    assign in_o[2] = i_ray.data.origin_z;
    assign in_d[0] = i_ray.data.delta_x;
    assign in_d[1] = i_ray.data.delta_y;
    assign in_d[2] = i_ray.data.delta_z;

    always_comb begin
        logic               below, above;
        logic signed [33:0] gap;
        for (int a = 0; a < 3; a++) begin
            below = in_o[a] < r_box_min[a];
            above = !below && (in_o[a] > r_box_max[a]);
            gap   = below ? 34'(r_box_min[a]) - 34'(in_o[a])
                          : 34'(r_box_max[a]) - 34'(in_o[a]);
            n_ax0[a].o   = in_o[a];
            n_ax0[a].d   = in_d[a];
            n_ax0[a].ins = !below && !above;
            n_ax0[a].neg = below;
            n_ax0[a].rej = below ? (gap > 34'(in_d[a]))
                                 : (above && (gap < 34'(in_d[a])));
            n_ax0[a].rem = mag34(gap);
            n_ax0[a].dv  = 32'(mag34(34'(in_d[a])));
            n_ax0[a].q   = '0;
        end
    end

    // ---------------- restoring divider ----------------
    t_axis_st r_ax [DIV_STAGES+1][3];
    logic     r_v  [DIV_STAGES+1];
    t_axis_st n_ax [DIV_STAGES+1][3];

    always_comb begin
        logic [32:0] rr;
        logic        ge;
        for (int a = 0; a < 3; a++) n_ax[0][a] = n_ax0[a];
        for (int j = 1; j <= DIV_STAGES; j++) begin
            for (int a = 0; a < 3; a++) begin
                // first step has no shift: on an axis neither inside nor rejected the gap never exceeds |delta|
                rr = (j == 1) ? r_ax[j-1][a].rem : {r_ax[j-1][a].rem[31:0], 1'b0};
                ge = rr >= {1'b0, r_ax[j-1][a].dv};
                n_ax[j][a]     = r_ax[j-1][a];
                n_ax[j][a].rem = ge ? rr - {1'b0, r_ax[j-1][a].dv} : rr;
                n_ax[j][a].q   = {r_ax[j-1][a].q[T_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= DIV_STAGES; j++) r_v[j] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_ray.valid;
            for (int j = 1; j <= DIV_STAGES; j++) r_v[j] <= r_v[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j <= DIV_STAGES; j++)
                for (int a = 0; a < 3; a++) r_ax[j][a] <= n_ax[j][a];
        end
    end

    // ---------------- face select ----------------
    logic                r_s_v;
    logic signed [31:0]  r_s_o [3];
    logic signed [31:0]  r_s_d [3];
    logic signed [T_W:0] r_s_best;
    logic [1:0]          r_s_which;
    logic                r_s_neg, r_s_inside, r_s_miss;

    logic signed [T_W:0] ts [3];
    logic signed [T_W:0] n_best;
    logic [1:0]          n_which;
    logic                n_neg;

    always_comb begin
        for (int a = 0; a < 3; a++)
            ts[a] = r_ax[DIV_STAGES][a].ins ? -(T_W+1)'(1)
                                            : $signed({1'b0, r_ax[DIV_STAGES][a].q});
        n_best  = ts[0];
        n_which = AXIS_X;
        n_neg   = r_ax[DIV_STAGES][0].neg;
        if (ts[1] > n_best) begin
            n_best  = ts[1];
            n_which = AXIS_Y;
            n_neg   = r_ax[DIV_STAGES][1].neg;
        end
        if (ts[2] > n_best) begin
            n_best  = ts[2];
            n_which = AXIS_Z;
            n_neg   = r_ax[DIV_STAGES][2].neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s_v <= 1'b0;
        else if (adv) r_s_v <= r_v[DIV_STAGES];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                r_s_o[a] <= r_ax[DIV_STAGES][a].o;
                r_s_d[a] <= r_ax[DIV_STAGES][a].d;
            end
            r_s_best   <= n_best;
            r_s_which  <= n_which;
            r_s_neg    <= n_neg;
            r_s_inside <= r_ax[DIV_STAGES][0].ins && r_ax[DIV_STAGES][1].ins
                          && r_ax[DIV_STAGES][2].ins;
            r_s_miss   <= r_ax[DIV_STAGES][0].rej || r_ax[DIV_STAGES][1].rej
                          || r_ax[DIV_STAGES][2].rej;
        end
    end

    // ---------------- multiply ----------------
    logic                r_m_v;
    logic signed [49:0]  r_m_prod [3];
    logic signed [31:0]  r_m_o [3];
    logic [T_W-1:0]      r_m_t;
    logic [1:0]          r_m_which;
    logic                r_m_neg, r_m_inside, r_m_miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m_v <= 1'b0;
        else if (adv) r_m_v <= r_s_v;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                r_m_prod[a] <= 50'(r_s_best) * 50'(r_s_d[a]);
                r_m_o[a]    <= r_s_o[a];
            end
            r_m_t      <= r_s_best[T_W-1:0];
            r_m_which  <= r_s_which;
            r_m_neg    <= r_s_neg;
            r_m_inside <= r_s_inside;
            r_m_miss   <= r_s_miss;
        end
    end

    // ---------------- bounds check / output ----------------
    t_result            r_out;
    t_result            n_out;
    logic signed [33:0] pt [3];
    logic               oob;

    always_comb begin
        logic signed [49:0] sh;
        oob = 1'b0;
        for (int a = 0; a < 3; a++) begin
            sh    = r_m_prod[a] >>> Q_BITS;   // floor towards minus infinity
            pt[a] = 34'(r_m_o[a]) + 34'(sh);
            if (2'(a) != r_m_which &&
                (pt[a] < 34'(r_box_min[a]) || pt[a] > 34'(r_box_max[a])))
                oob = 1'b1;
        end
        n_out = '0;
        if (r_m_miss) begin
            n_out = '0;
        end else if (r_m_inside) begin
            n_out.hit           = 1'b1;
            n_out.origin_inside = 1'b1;
            n_out.hit_x         = r_m_o[0];
            n_out.hit_y         = r_m_o[1];
            n_out.hit_z         = r_m_o[2];
        end else if (!oob) begin
            n_out.hit             = 1'b1;
            n_out.t_param         = r_m_t;
            n_out.normal_axis     = r_m_which;
            n_out.normal_negative = r_m_neg;
            n_out.hit_x           = pt[0][31:0];
            n_out.hit_y           = pt[1][31:0];
            n_out.hit_z           = pt[2][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (adv) r_out_v <= r_m_v;
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_out <= n_out;
    end

    assign o_res.valid = r_out_v;
    assign o_res.data  = r_out;

`ifndef ASSERT_OFF
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.hit) |-> (r_out.t_param == '0 && r_out.hit_x == '0
            && r_out.hit_y == '0 && r_out.hit_z == '0 && !r_out.origin_inside))
        else $error("miss beat carries non-zero fields");
    a_inside_t0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.origin_inside) |-> (r_out.hit && r_out.t_param == '0
            && r_out.normal_axis == AXIS_X && !r_out.normal_negative))
        else $error("inside beat with face or t");
    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out.t_param <= T_W'(1 << Q_BITS) && r_out.normal_axis != 2'd3))
        else $error("t or axis out of range");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_v && !adv) |=> r_m_v)
        else $error("pipeline stage lost a beat during stall");
`endif

endmodule
